[rtl/core/bson_pkg.sv]
// ----------------------------------------------------------------------------
// bson_pkg: shared types and codes for the BSON stream parser
// Byte roles, error codes, parser phases and element type codes.
// ----------------------------------------------------------------------------
package bson_pkg;

  typedef enum logic [3:0] {
    ROLE_DOCLEN  = 4'd0,
    ROLE_TYPE    = 4'd1,
    ROLE_NAME    = 4'd2,
    ROLE_NAMEEND = 4'd3,
    ROLE_LENPRE  = 4'd4,
    ROLE_SUBTYPE = 4'd5,
    ROLE_VALUE   = 4'd6,
    ROLE_DOCEND  = 4'd7,
    ROLE_DROP    = 4'd8
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_DEEP    = 2'd2,
    ERR_LENGTH  = 2'd3
  } err_t;

  typedef enum logic [6:0] {
    PH_DOCLEN  = 7'b0000001,
    PH_TYPE    = 7'b0000010,
    PH_NAME    = 7'b0000100,
    PH_LENPRE  = 7'b0001000,
    PH_SUBTYPE = 7'b0010000,
    PH_VALUE   = 7'b0100000,
    PH_DROP    = 7'b1000000
  } phase_t;

  localparam logic [7:0] T_DOUBLE = 8'h01;
  localparam logic [7:0] T_STRING = 8'h02;
  localparam logic [7:0] T_DOC    = 8'h03;
  localparam logic [7:0] T_ARRAY  = 8'h04;
  localparam logic [7:0] T_BINARY = 8'h05;
  localparam logic [7:0] T_OID    = 8'h07;
  localparam logic [7:0] T_BOOL   = 8'h08;
  localparam logic [7:0] T_INT32  = 8'h10;
  localparam logic [7:0] T_INT64  = 8'h12;

  localparam logic [31:0] LEN_MAX = 32'h7FFF_FFFF;

  // one tagged output word
  typedef struct packed {
    role_t      role;
    logic [7:0] etype;
    logic [3:0] depth;
    logic [7:0] data;
    logic       vlast;
    logic       dlast;
    err_t       err;
  } tag_t;

  function automatic logic known_type(input logic [7:0] t);
    known_type = (t == T_DOUBLE) || (t == T_STRING) || (t == T_DOC) ||
                 (t == T_ARRAY) || (t == T_BINARY) || (t == T_OID) ||
                 (t == T_BOOL) || (t == T_INT32) || (t == T_INT64);
  endfunction

endpackage

[rtl/core/bson_core.sv]
// ----------------------------------------------------------------------------
// bson_core: parser state and per-byte tagging
// Updates the parse state for one byte per cycle while step is high and produces its tag word.
// ----------------------------------------------------------------------------
module bson_core #(
  parameter int MAX_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  output bson_pkg::tag_t   tag
);
  import bson_pkg::*;

  localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  phase_t      phase, phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] length_accum, length_accum_next;
  logic [7:0]  current_type, current_type_next;
  logic [3:0]  level, level_next;
  logic [31:0] doc_remaining, doc_remaining_next;
  logic [31:0] remaining_stack [MAX_DEPTH];
  logic        push, pop_wr;
  logic [SW-1:0] wr_idx;
  logic [31:0] wr_data;

  logic [31:0] acc_new, parent_rem;
  logic        can_take;
  logic [SW-1:0] parent_idx;

  // parent entry sits one below the current level, for both length check and pop
  assign parent_idx = SW'(level - 4'd1);
  assign parent_rem = remaining_stack[parent_idx];
  assign can_take   = (doc_remaining >= 32'd2);

  always_comb begin
    case (field_count[1:0])
      2'd0:    acc_new = length_accum | {24'd0, data_byte};
      2'd1:    acc_new = length_accum | {16'd0, data_byte, 8'd0};
      2'd2:    acc_new = length_accum | {8'd0, data_byte, 16'd0};
      default: acc_new = length_accum | {data_byte, 24'd0};
    endcase
  end

  // next state and tag
  always_comb begin
    phase_next = phase;
    field_count_next = field_count;
    length_accum_next = length_accum;
    current_type_next = current_type;
    level_next = level;
    doc_remaining_next = doc_remaining;
    push = 1'b0;
    pop_wr = 1'b0;
    wr_idx = SW'(level);
    wr_data = doc_remaining;
    tag = '0;
    tag.role = ROLE_DROP;
    tag.depth = level;
    tag.data = data_byte;
    tag.err = ERR_NONE;
    case (phase)
      PH_DOCLEN: begin
        tag.role = ROLE_DOCLEN;
        tag.etype = (level != 4'd0) ? current_type : 8'd0;
        length_accum_next = acc_new;
        field_count_next = field_count + 32'd1;
        if (field_count_next >= 32'd4) begin
          field_count_next = '0;
          if (acc_new < 32'd5 || acc_new > LEN_MAX) begin
            tag.err = ERR_LENGTH;
          end else if (level == 4'd0) begin
            doc_remaining_next = acc_new - 32'd4;
            phase_next = PH_TYPE;
          end else if (32'(level) - 32'd1 < 32'(MAX_DEPTH) && acc_new < parent_rem) begin
            pop_wr = 1'b1;
            wr_idx = parent_idx;
            wr_data = parent_rem - acc_new;
            doc_remaining_next = acc_new - 32'd4;
            phase_next = PH_TYPE;
          end else begin
            tag.err = ERR_LENGTH;
          end
        end
      end
      PH_TYPE: begin
        if (data_byte == 8'd0) begin
          tag.role = ROLE_DOCEND;
          tag.dlast = 1'b1;
          if (doc_remaining != 32'd1) begin
            tag.err = ERR_LENGTH;
          end else if (level == 4'd0) begin
            doc_remaining_next = '0;
            current_type_next = '0;
            length_accum_next = '0;
            field_count_next = '0;
            phase_next = PH_DOCLEN;
          end else begin
            level_next = level - 4'd1;
            doc_remaining_next = (32'(level) - 32'd1 < 32'(MAX_DEPTH)) ? parent_rem : 32'd0;
          end
        end else begin
          tag.role = ROLE_TYPE;
          tag.etype = data_byte;
          if (!can_take) begin
            tag.err = ERR_LENGTH;
          end else begin
            doc_remaining_next = doc_remaining - 32'd1;
            if (!known_type(data_byte)) begin
              tag.err = ERR_UNKNOWN;
            end else begin
              current_type_next = data_byte;
              phase_next = PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        tag.role = (data_byte == 8'd0) ? ROLE_NAMEEND : ROLE_NAME;
        tag.etype = current_type;
        if (!can_take) begin
          tag.err = ERR_LENGTH;
        end else begin
          doc_remaining_next = doc_remaining - 32'd1;
          if (data_byte == 8'd0) begin
            case (current_type)
              T_DOUBLE, T_INT64: begin
                field_count_next = 32'd8;  phase_next = PH_VALUE;
              end
              T_OID: begin
                field_count_next = 32'd12; phase_next = PH_VALUE;
              end
              T_BOOL: begin
                field_count_next = 32'd1;  phase_next = PH_VALUE;
              end
              T_INT32: begin
                field_count_next = 32'd4;  phase_next = PH_VALUE;
              end
              T_STRING, T_BINARY: begin
                field_count_next = '0;
                length_accum_next = '0;
                phase_next = PH_LENPRE;
              end
              default: begin
                if (32'(level) >= 32'(MAX_DEPTH)) begin
                  tag.err = ERR_DEEP;
                end else begin
                  push = 1'b1;
                  wr_idx = SW'(level);
                  wr_data = doc_remaining - 32'd1;
                  level_next = level + 4'd1;
                  field_count_next = '0;
                  length_accum_next = '0;
                  phase_next = PH_DOCLEN;
                end
              end
            endcase
          end
        end
      end
      PH_LENPRE: begin
        tag.role = ROLE_LENPRE;
        tag.etype = current_type;
        if (!can_take) begin
          tag.err = ERR_LENGTH;
        end else begin
          doc_remaining_next = doc_remaining - 32'd1;
          length_accum_next = acc_new;
          field_count_next = field_count + 32'd1;
          if (field_count_next >= 32'd4) begin
            field_count_next = '0;
            if (acc_new > LEN_MAX) begin
              tag.err = ERR_LENGTH;
            end else if (current_type == T_BINARY) begin
              phase_next = PH_SUBTYPE;
            end else if (acc_new == 32'd0) begin
              tag.err = ERR_LENGTH;
            end else begin
              field_count_next = acc_new;
              phase_next = PH_VALUE;
            end
          end
        end
      end
      PH_SUBTYPE: begin
        tag.role = ROLE_SUBTYPE;
        tag.etype = current_type;
        if (!can_take) begin
          tag.err = ERR_LENGTH;
        end else begin
          doc_remaining_next = doc_remaining - 32'd1;
          if (length_accum == 32'd0) begin
            tag.vlast = 1'b1;
            phase_next = PH_TYPE;
          end else begin
            field_count_next = length_accum;
            phase_next = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        tag.role = ROLE_VALUE;
        tag.etype = current_type;
        if (!can_take) begin
          tag.err = ERR_LENGTH;
        end else begin
          doc_remaining_next = doc_remaining - 32'd1;
          if (field_count != 32'd0) field_count_next = field_count - 32'd1;
          if (field_count_next == 32'd0) begin
            tag.vlast = 1'b1;
            phase_next = PH_TYPE;
          end
        end
      end
      default: begin
        tag.role = ROLE_DROP;
      end
    endcase
    if (tag.err != ERR_NONE) phase_next = PH_DROP;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DOCLEN;
      field_count <= '0;
      length_accum <= '0;
      current_type <= '0;
      level <= '0;
      doc_remaining <= '0;
    end else if (step) begin
      phase <= phase_next;
      field_count <= field_count_next;
      length_accum <= length_accum_next;
      current_type <= current_type_next;
      level <= level_next;
      doc_remaining <= doc_remaining_next;
    end
  end

  // enclosing document byte counts
  always_ff @(posedge clk) begin
    if (step && (push || pop_wr)) remaining_stack[wr_idx] <= wr_data;
  end

endmodule

[rtl/core/bson_stream_parser.sv]
// ----------------------------------------------------------------------------
// bson_stream_parser: streaming BSON document tagger
// Tags every byte of a BSON stream with role, type, depth and end marks.
// ----------------------------------------------------------------------------
// Output: the tag word is registered and shown in the cycle after its input word is accepted.
// Throughput: one word per cycle unless out_ready stalls; parse state updates once per byte.
// Reset: synchronous rst clears parser to expect a document length; the
// depth stack is not cleared, every entry is pushed before it is read.
module bson_stream_parser #(
  parameter int MAX_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] byte_role,
  output logic [7:0] element_type,
  output logic [3:0] nest_depth,
  output logic [7:0] byte_out,
  output logic       value_last,
  output logic       doc_last,
  output logic [1:0] error_code
);
  import bson_pkg::*;

  tag_t tag, out_reg;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  bson_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
    .clk(clk), .rst(rst), .step(step), .data_byte(data_byte), .tag(tag)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_reg <= tag;
  end

  assign byte_role    = out_reg.role;
  assign element_type = out_reg.etype;
  assign nest_depth   = out_reg.depth;
  assign byte_out     = out_reg.data;
  assign value_last   = out_reg.vlast;
  assign doc_last     = out_reg.dlast;
  assign error_code   = out_reg.err;

endmodule
